FILE: hw/rtl/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared widths, action and status codes, and controller/datapath bundles
// for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int ACTION_W = 3;
   localparam int VALUE_W  = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_LIST_FWD   = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_LIST_BWD   = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic accept;
      logic step;
   } deq_cmd_type;

   typedef struct packed {
      logic act_ok;
      logic list_more;
   } deq_stat_type;

endpackage
`default_nettype wire

FILE: hw/rtl/deq_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_req_if
// Request channel: action and value with valid/ready handshake.
// ----------------------------------------------------------------------------
interface deq_req_if import deq_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [VALUE_W-1:0]  value;

   modport source (output valid, output action, output value, input ready);
   modport sink   (input valid, input action, input value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/deq_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_rsp_if
// Response channel: status, value, last marker and count with valid/ready.
// ----------------------------------------------------------------------------
interface deq_rsp_if import deq_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  value_res;
   logic                last;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output status, output value_res, output last,
                   output count, input ready);
   modport sink   (input valid, input status, input value_res, input last,
                   input count, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/deq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl
// Controller: takes one request, then holds the response until each
// transaction of it has been taken, stepping through listings.
// ----------------------------------------------------------------------------
module deq_ctrl import deq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire deq_stat_type stat,
   output deq_cmd_type       cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SEND = 2'b10
   } deq_state_type;

   deq_state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd.accept = 1'b0;
      cmd.step   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (stat.act_ok) state_in = S_SEND;
            end
         end
         S_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (stat.list_more) cmd.step = 1'b1;
               else state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule
`default_nettype wire

FILE: hw/rtl/deq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_dp
// Datapath: ring buffer memory, front pointer, entry count, listing cursor
// and the response registers.
// ----------------------------------------------------------------------------
module deq_dp import deq_pkg::*;
#(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 16
)
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire deq_cmd_type         cmd,
   output deq_stat_type             stat,
   input  wire logic [ACTION_W-1:0] req_action,
   input  wire logic [VALUE_W-1:0]  req_value,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [VALUE_W-1:0]       rsp_value_res,
   output logic                     rsp_last,
   output logic [COUNT_W-1:0]       rsp_count
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int VWIDE = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
   localparam int CWIDE = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [AW:0]   LIMIT   = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] FULL_CT = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_SL = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= LIMIT) sum = sum - LIMIT;
      return sum[AW-1:0];
   endfunction

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_ff;

   logic [AW-1:0]         front_ff, front_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  list_ff, list_in;
   logic                  fwd_ff, fwd_in;
   logic [AW-1:0]         off_ff, off_in;
   logic [AW-1:0]         rem_ff, rem_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  last_ff, last_in;
   logic                  use_mem_ff, use_mem_in;

   logic                  wr_en, rd_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [VWIDE-1:0]      val_wide, rd_wide;
   logic [CWIDE-1:0]      cnt_wide;
   logic [CW-1:0]         cm1_full;
   logic [AW-1:0]         cm1, front_dec, off_next;
   logic                  is_full, is_empty;

   assign val_wide  = VWIDE'(req_value);
   assign wr_data   = val_wide[DATA_WIDTH-1:0];
   assign cm1_full  = count_ff - CW'(1);
   assign cm1       = cm1_full[AW-1:0];
   assign front_dec = (front_ff == '0) ? LAST_SL : front_ff - AW'(1);
   assign off_next  = fwd_ff ? off_ff + AW'(1) : off_ff - AW'(1);
   assign is_full   = (count_ff == FULL_CT);
   assign is_empty  = (count_ff == '0);

   assign stat.act_ok    = (req_action <= ACT_LIST_BWD);
   assign stat.list_more = list_ff && (rem_ff != '0);

   always_comb begin
      front_in   = front_ff;
      count_in   = count_ff;
      list_in    = list_ff;
      fwd_in     = fwd_ff;
      off_in     = off_ff;
      rem_in     = rem_ff;
      status_in  = status_ff;
      last_in    = last_ff;
      use_mem_in = use_mem_ff;
      wr_en      = 1'b0;
      wr_addr    = front_ff;
      rd_en      = 1'b0;
      rd_addr    = front_ff;
      if (cmd.accept) begin
         unique case (req_action)
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
               last_in    = 1'b1;
               use_mem_in = 1'b0;
               list_in    = 1'b0;
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_OK;
                  wr_en     = 1'b1;
                  count_in  = count_ff + CW'(1);
                  if (req_action == ACT_PUSH_FRONT) begin
                     front_in = front_dec;
                     wr_addr  = front_dec;
                  end else begin
                     wr_addr = slot_of(front_ff, count_ff[AW-1:0]);
                  end
               end
            end
            ACT_POP_FRONT, ACT_POP_BACK, ACT_LIST_FWD, ACT_LIST_BWD: begin
               list_in = 1'b0;
               last_in = 1'b1;
               if (is_empty) begin
                  status_in  = ST_EMPTY;
                  use_mem_in = 1'b0;
               end else begin
                  status_in  = ST_OK;
                  use_mem_in = 1'b1;
                  rd_en      = 1'b1;
                  if (req_action == ACT_POP_FRONT) begin
                     rd_addr  = front_ff;
                     front_in = slot_of(front_ff, AW'(1));
                     count_in = cm1_full;
                  end else if (req_action == ACT_POP_BACK) begin
                     rd_addr  = slot_of(front_ff, cm1);
                     count_in = cm1_full;
                  end else begin
                     list_in = 1'b1;
                     rem_in  = cm1;
                     last_in = (cm1 == '0);
                     fwd_in  = (req_action == ACT_LIST_FWD);
                     if (req_action == ACT_LIST_FWD) begin
                        off_in  = '0;
                        rd_addr = front_ff;
                     end else begin
                        off_in  = cm1;
                        rd_addr = slot_of(front_ff, cm1);
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.step) begin
         rd_en   = 1'b1;
         rd_addr = slot_of(front_ff, off_next);
         off_in  = off_next;
         rem_in  = rem_ff - AW'(1);
         last_in = (rem_ff == AW'(1));
      end
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
         list_ff  <= 1'b0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
         list_ff  <= list_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_ff     <= fwd_in;
      off_ff     <= off_in;
      rem_ff     <= rem_in;
      status_ff  <= status_in;
      last_ff    <= last_in;
      use_mem_ff <= use_mem_in;
   end

   assign rd_wide       = VWIDE'(rd_ff);
   assign cnt_wide      = CWIDE'(count_ff);
   assign rsp_status    = status_ff;
   assign rsp_value_res = use_mem_ff ? rd_wide[VALUE_W-1:0] : '0;
   assign rsp_last      = last_ff;
   assign rsp_count     = cnt_wide[COUNT_W-1:0];

endmodule
`default_nettype wire

FILE: hw/rtl/double_ended_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue of identifiers held in a ring buffer memory.
// ----------------------------------------------------------------------------
// A request is taken only while no response is pending. Push and pop give one
// response transaction in the cycle after the request is taken, and the next request
// is taken only after that response has been taken.
// A listing of N entries gives N response transactions, one per cycle while
// the sink is ready, read in turn through the single read port of the entry
// memory; the next request is taken after the transaction marked last.
// Unused action codes are taken and give no response. No clearing pass is
// needed after reset.
module double_ended_queue import deq_pkg::*;
#(
   parameter int DEPTH      = 32,
   parameter int DATA_WIDTH = 16
)
(
   input wire logic  clock,
   input wire logic  reset,
   deq_req_if.sink   req_if,
   deq_rsp_if.source rsp_if
);

   deq_cmd_type  cmd;
   deq_stat_type stat;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   deq_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_action    (req_if.action),
      .req_value     (req_if.value),
      .rsp_status    (rsp_if.status),
      .rsp_value_res (rsp_if.value_res),
      .rsp_last      (rsp_if.last),
      .rsp_count     (rsp_if.count)
   );

   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      !(req_if.valid && req_if.ready && rsp_if.valid))
      else $error("request taken while a response is pending");

   a_list_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.ready && !rsp_if.last) |=> rsp_if.valid)
      else $error("listing stopped before its last transaction");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status != ST_OK) |-> rsp_if.last)
      else $error("empty or full status without last marker");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.status == ST_EMPTY)
         |-> (rsp_if.count == '0 && rsp_if.value_res == '0))
      else $error("empty status with nonzero count or value");

endmodule
`default_nettype wire

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the double-ended queue. A short table of directed
// transactions covers the empty cases, the extreme identifiers, every action
// and the unused action codes. Random phases then fill the ring past full,
// drain it past empty and mix all actions. Every response is compared with
// its table reply or a shadow deque kept in the bench. Random idling falls
// on both channels, with one long hold-off on the response side.
// ----------------------------------------------------------------------------
module testbench;
   import deq_pkg::*;

   localparam int QUEUE_DEPTH = 32;
   localparam int IDLE_LIMIT  = 1000;
   localparam int HOLD_CYCLES = 80;
   localparam int HOLD_AFTER  = 90;
   localparam int SETTLE      = 8;
   localparam int MAX_REPORTS = 10;

   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

   typedef enum logic [1:0] {MODE_FILL, MODE_DRAIN, MODE_MIXED} phase_mode_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value_res;
      logic                last;
      logic [COUNT_W-1:0]  count;
   } reply_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [VALUE_W-1:0]  value;
      logic                typed;
      reply_type           reply;
   } stim_row_type;

   localparam int N_ROWS = 21;

   // typed rows carry their response, the rest follow the shadow deque
   localparam stim_row_type DIRECTED_ROWS [N_ROWS] = '{
      '{ACT_POP_FRONT,  16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, 1'b1, 6'd0}},
      '{ACT_POP_BACK,   16'hffff, 1'b1, '{ST_EMPTY, 16'h0000, 1'b1, 6'd0}},
      '{ACT_LIST_FWD,   16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, 1'b1, 6'd0}},
      '{ACT_LIST_BWD,   16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, 1'b1, 6'd0}},
      '{ACT_SPARE_LO,   16'h5a5a, 1'b0, '0},
      '{ACT_PUSH_FRONT, 16'hffff, 1'b1, '{ST_OK,    16'h0000, 1'b1, 6'd1}},
      '{ACT_SPARE_HI,   16'hffff, 1'b0, '0},
      '{ACT_PUSH_BACK,  16'h0000, 1'b1, '{ST_OK,    16'h0000, 1'b1, 6'd2}},
      '{ACT_PUSH_FRONT, 16'h1234, 1'b0, '0},
      '{ACT_PUSH_BACK,  16'ha5a5, 1'b0, '0},
      '{ACT_LIST_FWD,   16'h0000, 1'b0, '0},
      '{ACT_LIST_BWD,   16'hffff, 1'b0, '0},
      '{ACT_POP_FRONT,  16'h0000, 1'b0, '0},
      '{ACT_POP_BACK,   16'h0000, 1'b0, '0},
      '{ACT_LIST_FWD,   16'h0000, 1'b0, '0},
      '{ACT_POP_FRONT,  16'hffff, 1'b0, '0},
      '{ACT_POP_BACK,   16'h0000, 1'b0, '0},
      '{ACT_POP_BACK,   16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, 1'b1, 6'd0}},
      '{ACT_PUSH_BACK,  16'h8001, 1'b0, '0},
      '{ACT_POP_FRONT,  16'h0000, 1'b0, '0},
      '{ACT_LIST_BWD,   16'h0000, 1'b1, '{ST_EMPTY, 16'h0000, 1'b1, 6'd0}}
   };

   logic clock;
   logic reset;

   deq_req_if req_ch ();
   deq_rsp_if rsp_ch ();

   double_ended_queue DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   // shadow copy of the ring
   logic [VALUE_W-1:0] shadow_slots [QUEUE_DEPTH];
   logic [4:0]         shadow_head = '0;
   logic [COUNT_W-1:0] shadow_fill = '0;

   reply_type step_replies [$];
   reply_type owed_replies [$];

   int  fault_count    = 0;
   int  accepted_items = 0;
   int  idle_cycles    = 0;
   bit  calm           = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void deque_action(input logic [ACTION_W-1:0] act,
                                        input logic [VALUE_W-1:0]  val);
      logic [4:0] pos;
      reply_type  r;
      step_replies.delete();
      r = '0;
      r.last = 1'b1;
      unique case (act)
         ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
            if (shadow_fill == QUEUE_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (act == ACT_PUSH_FRONT) begin
                  shadow_head = shadow_head - 5'd1;
                  shadow_slots[shadow_head] = val;
               end else begin
                  pos = shadow_head + shadow_fill[4:0];
                  shadow_slots[pos] = val;
               end
               shadow_fill = shadow_fill + 6'd1;
               r.status = ST_OK;
            end
            r.count = shadow_fill;
            step_replies.push_back(r);
         end
         ACT_POP_FRONT, ACT_POP_BACK, ACT_LIST_FWD, ACT_LIST_BWD: begin
            if (shadow_fill == 0) begin
               r.status = ST_EMPTY;
               step_replies.push_back(r);
            end else if (act == ACT_POP_FRONT) begin
               r.value_res = shadow_slots[shadow_head];
               shadow_head = shadow_head + 5'd1;
               shadow_fill = shadow_fill - 6'd1;
               r.count = shadow_fill;
               step_replies.push_back(r);
            end else if (act == ACT_POP_BACK) begin
               pos = shadow_head + shadow_fill[4:0] - 5'd1;
               r.value_res = shadow_slots[pos];
               shadow_fill = shadow_fill - 6'd1;
               r.count = shadow_fill;
               step_replies.push_back(r);
            end else begin
               for (int i = 0; i < shadow_fill; i++) begin
                  if (act == ACT_LIST_FWD) begin
                     pos = shadow_head + 5'(i);
                  end else begin
                     pos = shadow_head + 5'(shadow_fill - 1 - i);
                  end
                  r.value_res = shadow_slots[pos];
                  r.last      = (i == shadow_fill - 1);
                  r.count     = shadow_fill;
                  step_replies.push_back(r);
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic logic [ACTION_W-1:0] draw_action(input phase_mode_type mode);
      int roll;
      int push_cut;
      int pop_cut;
      int list_cut;
      roll = $urandom_range(0, 99);
      unique case (mode)
         MODE_FILL: begin
            push_cut = 80; pop_cut = 88; list_cut = 95;
         end
         MODE_DRAIN: begin
            push_cut = 15; pop_cut = 83; list_cut = 93;
         end
         default: begin
            push_cut = 40; pop_cut = 75; list_cut = 93;
         end
      endcase
      if (roll < push_cut)
         return ($urandom_range(0, 1) != 0) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
      if (roll < pop_cut)
         return ($urandom_range(0, 1) != 0) ? ACT_POP_BACK : ACT_POP_FRONT;
      if (roll < list_cut)
         return ($urandom_range(0, 1) != 0) ? ACT_LIST_BWD : ACT_LIST_FWD;
      return ($urandom_range(0, 1) != 0) ? ACT_SPARE_HI : ACT_SPARE_LO;
   endfunction

   // offer one transaction, update the shadow deque when it is taken
   task automatic offer_request(input logic [ACTION_W-1:0] act,
                                input logic [VALUE_W-1:0]  val,
                                input bit                  take_prediction);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.value  <= val;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      deque_action(act, val);
      accepted_items++;
      if (take_prediction) begin
         foreach (step_replies[k]) owed_replies.push_back(step_replies[k]);
      end
   endtask

   // response side: short stall bursts and one long hold-off
   initial begin
      bit held_off;
      held_off = 1'b0;
      rsp_ch.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (!held_off && accepted_items >= HOLD_AFTER) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = {rsp_ch.status, rsp_ch.value_res, rsp_ch.last, rsp_ch.count};
         if (owed_replies.size() == 0) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS)
               $display("unexpected transaction: status %0d value %h last %0d count %0d",
                        got.status, got.value_res, got.last, got.count);
         end else begin
            want = owed_replies.pop_front();
            if (got.status !== want.status || got.value_res !== want.value_res ||
                got.last !== want.last || got.count !== want.count) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS) begin
                  $write("mismatch: expected status %0d value %h last %0d count %0d,",
                         want.status, want.value_res, want.last, want.count);
                  $display(" got status %0d value %h last %0d count %0d",
                           got.status, got.value_res, got.last, got.count);
               end
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   initial begin
      phase_mode_type      plan_mode [5];
      int                  plan_len  [5];
      int                  done;
      logic [ACTION_W-1:0] act;
      logic [VALUE_W-1:0]  val;
      int                  pick;

      plan_mode = '{MODE_FILL, MODE_MIXED, MODE_DRAIN, MODE_FILL, MODE_MIXED};
      plan_len  = '{45, 35, 45, 35, 30};

      reset         <= 1'b1;
      req_ch.valid  <= 1'b0;
      req_ch.action <= ACT_PUSH_FRONT;
      req_ch.value  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[k]) begin
         offer_request(DIRECTED_ROWS[k].action, DIRECTED_ROWS[k].value,
                       !DIRECTED_ROWS[k].typed);
         if (DIRECTED_ROWS[k].typed) owed_replies.push_back(DIRECTED_ROWS[k].reply);
      end

      foreach (plan_mode[p]) begin
         if (p == 4) calm = 1'b1;
         done = 0;
         while (done < plan_len[p]) begin
            act  = draw_action(plan_mode[p]);
            pick = $urandom_range(0, 7);
            if (pick == 0) val = 16'hffff;
            else if (pick == 1) val = 16'h0000;
            else val = 16'($urandom_range(0, 65535));
            offer_request(act, val, 1'b1);
            if (act <= ACT_LIST_BWD) done++;
         end
      end
      req_ch.valid <= 1'b0;

      while (owed_replies.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (fault_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
